// File: design/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and opcode codes for the de-duplicating set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  typedef logic [OP_W-1:0]         opcode_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        index_t;
  typedef logic [CNT_W-1:0]        count_t;

  localparam opcode_t OP_ADD      = 3'd0;
  localparam opcode_t OP_REMOVE   = 3'd1;
  localparam opcode_t OP_CONTAINS = 3'd2;
  localparam opcode_t OP_CLEAR    = 3'd3;
  localparam opcode_t OP_READ     = 3'd4;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;     // register the match flag
    logic add;     // write the value into the first free cell
    logic remove;  // shift down from the matching cell onwards
  } ctl_t;

endpackage

`default_nettype wire

// File: design/dst_cell.sv
// ----------------------------------------------------------------------------
// dst_cell
// One table position: holds an entry, flags a match, shifts down on removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_cell #(
  parameter int POS = 0,
  parameter int CW  = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dst_pkg::ctl_t   ctl,
  input  wire dst_pkg::value_t value,
  input  wire logic [CW-1:0]   count,
  input  wire dst_pkg::value_t entry_in,
  input  wire logic            shift_in,
  output dst_pkg::value_t      entry,
  output logic                 shift_out
);
  import dst_pkg::*;

  localparam logic [CW-1:0] POS_C = CW'(POS);

  logic occ;
  logic hit;

  assign occ       = POS_C < count;
  assign shift_out = shift_in | hit;

  // Register the match of the broadcast value against this entry
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= occ && (entry == value);
    end
  end

  // Take the neighbour's entry on removal, or the new value on append
  always_ff @(posedge clk) begin
    if (ctl.remove && shift_out) begin
      entry <= entry_in;
    end else if (ctl.add && (POS_C == count)) begin
      entry <= value;
    end
  end

endmodule

`default_nettype wire

// File: design/dedup_set_table.sv
// ----------------------------------------------------------------------------
// dedup_set_table
// Set of distinct 32-bit values in insertion order, built as a row of cells.
// ----------------------------------------------------------------------------
// Each item passes through two steps: one in which every cell compares the
// value in parallel and registers its match flag, and one in which the cells
// append, shift down to close a gap, and the result is written to the output
// register. A new item is accepted in the same cycle as the previous result
// is written, so items follow one another without a gap while the output
// side keeps up. The output register holds a result until it is taken, and
// the next item can already be accepted behind it. Add reports full_error
// when the value is new and all DEPTH cells are occupied; read reaches
// positions 0 to 15; count shows the low five bits of the occupancy.
`timescale 1ns / 1ps
`default_nettype none

module dedup_set_table #(
  parameter int DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dst_pkg::opcode_t opcode,
  input  wire dst_pkg::value_t value,
  input  wire dst_pkg::index_t index,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 answer,
  output logic                 full_error,
  output dst_pkg::count_t      count,
  output dst_pkg::value_t      element
);
  import dst_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  opcode_t       op_q;
  value_t        value_q;
  index_t        index_q;
  logic [CW-1:0] occ_count;
  logic [CW-1:0] occ_count_next;
  value_t        rd_data;
  logic          rd_ok;
  value_t        rd_sel;

  logic          in_fire;
  logic          apply_fire;
  logic          any_hit;
  ctl_t          ctl;

  value_t        entry [DEPTH];
  logic [DEPTH:0] shift_chain;

  logic          res_answer;
  logic          res_full;
  value_t        res_element;
  logic [CW+4:0] cnt_wide;

  assign apply_fire = (state == S_APPLY) && (!out_valid || out_ready);
  assign in_ready   = (state == S_IDLE) || apply_fire;
  assign in_fire    = in_valid && in_ready;
  assign any_hit    = shift_chain[DEPTH];

  // Broadcast control to the cells
  always_comb begin
    ctl.cmp    = (state == S_CMP);
    ctl.add    = apply_fire && (op_q == OP_ADD) && !any_hit;
    ctl.remove = apply_fire && (op_q == OP_REMOVE);
  end

  // Row of cells; each takes its upper neighbour's entry on removal
  assign shift_chain[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    value_t nb;
    if (g == DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = entry[g+1];
    end
    dst_cell #(
      .POS (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .value     (value_q),
      .count     (occ_count),
      .entry_in  (nb),
      .shift_in  (shift_chain[g]),
      .entry     (entry[g]),
      .shift_out (shift_chain[g+1])
    );
  end

  // Select the entry at the read position
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(index_q) == i) begin
        rd_sel = entry[i];
      end
    end
  end

  // Sequencer: idle, compare, apply
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (apply_fire) state_next = in_fire ? S_CMP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= opcode;
      value_q <= value;
      index_q <= index;
    end
  end

  // Register the read data during the compare cycle
  always_ff @(posedge clk) begin
    if (state == S_CMP) begin
      rd_data <= rd_sel;
      rd_ok   <= (CW+4)'(index_q) < (CW+4)'(occ_count);
    end
  end

  // Work out the result and the new occupancy
  always_comb begin
    res_answer     = 1'b0;
    res_full       = 1'b0;
    res_element    = '0;
    occ_count_next = occ_count;
    case (op_q)
      OP_ADD: begin
        if (!any_hit) begin
          if (occ_count < DEPTH_C) begin
            res_answer     = 1'b1;
            occ_count_next = occ_count + CW'(1);
          end else begin
            res_full = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          res_answer     = 1'b1;
          occ_count_next = occ_count - CW'(1);
        end
      end
      OP_CONTAINS: res_answer = any_hit;
      OP_CLEAR:    occ_count_next = '0;
      OP_READ: begin
        res_answer  = rd_ok;
        res_element = rd_ok ? rd_data : '0;
      end
      default: ;
    endcase
  end

  assign cnt_wide = (CW+5)'(occ_count_next);

  // Occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      occ_count <= '0;
    end else if (apply_fire) begin
      occ_count <= occ_count_next;
    end
  end

  // Output register: load on apply, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      answer     <= res_answer;
      full_error <= res_full;
      count      <= cnt_wide[4:0];
      element    <= res_element;
    end
  end

endmodule

`default_nettype wire

// File: design/dst_checker.sv
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks on the set table's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dst_checker #(
  parameter int DEPTH = 16
) (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            answer,
  input wire logic            full_error,
  input wire dst_pkg::count_t count,
  input wire dst_pkg::value_t element
);
  import dst_pkg::*;

  localparam count_t FULL_C = CNT_W'(DEPTH);

  // A dropped add never also reports an insertion
  assert property (@(posedge clk) disable iff (rst)
    out_valid && full_error |-> !answer)
    else $error("full_error with answer set");

  // Overflow is only reported with every entry occupied
  assert property (@(posedge clk) disable iff (rst)
    out_valid && full_error && (DEPTH < 32) |-> count == FULL_C)
    else $error("full_error while not full");

  // A non-zero element only comes with a valid read
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (element != '0) |-> answer && !full_error)
    else $error("element without a valid read");

  // Occupancy never exceeds the table depth
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (DEPTH < 32) |-> count <= FULL_C)
    else $error("count beyond depth");

  // A stalled result beat stays valid and holds its count and element
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(element))
    else $error("result beat changed while stalled");

endmodule

bind dedup_set_table dst_checker #(
  .DEPTH (DEPTH)
) u_dst_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .answer     (answer),
  .full_error (full_error),
  .count      (count),
  .element    (element)
);

`default_nettype wire
